// ===== rtl/ata_chs_request_sequencer_assert.svh =====
// Assertion macros shared by the checker.
`ifndef ATA_CHS_REQUEST_SEQUENCER_ASSERT_SVH
`define ATA_CHS_REQUEST_SEQUENCER_ASSERT_SVH
// a |-> b, disabled during reset
`define ACRS_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// a |=> b, disabled during reset
`define ACRS_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ===== rtl/acrs_pkg.sv =====
// Package: widths, command codes, task-file opcodes and shared types.
package acrs_pkg;
  localparam int PartitionSlotsDef = 10;
  localparam int DriveCountMaxDef = 2;
  localparam int ErrorLimitDef = 7;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;
  localparam int InDataW = 128;
  localparam int InUserW = 2;
  localparam int OutDataW = 16;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_REQUEST = 2'd1;
  localparam logic [1:0] CMD_STATUS = 2'd2;

  localparam logic [2:0] REG_SPT0 = 3'd0;
  localparam logic [2:0] REG_HEADS0 = 3'd1;
  localparam logic [2:0] REG_CYL0 = 3'd2;
  localparam logic [2:0] REG_SPT1 = 3'd3;
  localparam logic [2:0] REG_HEADS1 = 3'd4;
  localparam logic [2:0] REG_CYL1 = 3'd5;
  localparam logic [2:0] REG_CTRL = 3'd6;
  localparam logic [2:0] REG_PRECOMP = 3'd7;

  localparam logic [7:0] OP_SPECIFY = 8'h91;
  localparam logic [7:0] OP_RESTORE = 8'h10;
  localparam logic [7:0] OP_READ = 8'h20;
  localparam logic [7:0] OP_WRITE = 8'h30;
  localparam logic [7:0] DEV_HEAD_BASE = 8'ha0;
  localparam logic [7:0] CTRL_SRST = 8'h04;
  localparam logic [7:0] CTRL_MASK = 8'h0f;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_SPECIFY = 2'd1;
  localparam logic [1:0] KIND_RESTORE = 2'd2;
  localparam logic [1:0] KIND_XFER = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic div_start;   // start a division
    logic div_second;  // run second division (q / heads)
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
  } dp_stat_t;
endpackage

// ===== rtl/acrs_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module acrs_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [7:0]  divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [7:0]  remainder
);
  logic [31:0] q;
  logic [8:0]  r;
  logic [5:0]  cnt;
  logic        busy;
  logic [8:0]  shifted;
  logic [9:0]  diff;

  assign shifted = {r[7:0], q[31]};
  assign diff = {1'b0, shifted} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd32;
        q <= dividend;
        r <= '0;
      end else if (busy) begin
        if (diff[9]) begin
          r <= shifted;
          q <= {q[30:0], 1'b0};
        end else begin
          r <= diff[8:0];
          q <= {q[30:0], 1'b1};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = q;
  assign remainder = r[7:0];
endmodule

// ===== rtl/acrs_datapath.sv =====
// Datapath: partition table, address arithmetic and divisions.
module acrs_datapath #(
  parameter int PARTITION_SLOTS = acrs_pkg::PartitionSlotsDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                load_en,
  input  logic [3:0]          load_slot,
  input  logic [31:0]         load_start,
  input  logic [31:0]         load_length,
  input  logic [3:0]          dev,
  input  logic [31:0]         rel_sector,
  input  logic [7:0]          spt,
  input  logic [4:0]          heads,
  input  acrs_pkg::dp_cmd_t   cmd,
  output acrs_pkg::dp_stat_t  stat,
  output logic                len_ok,
  output logic [7:0]          sec_out,
  output logic [3:0]          head_out,
  output logic [15:0]         cyl_out
);
  import acrs_pkg::*;

  logic [31:0] part_start [PARTITION_SLOTS];
  logic [31:0] part_len [PARTITION_SLOTS];
  logic [PARTITION_SLOTS-1:0] slot_valid;
  logic [31:0] sel_start, sel_len;
  logic [31:0] div_a;
  logic [7:0]  div_b;
  logic        div_go, div_done;
  logic [31:0] quo;
  logic [7:0]  rem;
  logic        run_second;  // the running division is q / heads

  always_comb begin
    sel_start = '0;
    sel_len = '0;
    for (int i = 0; i < PARTITION_SLOTS; i++) begin
      if (dev == 4'(i) && slot_valid[i]) begin
        sel_start = part_start[i];
        sel_len = part_len[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (load_en && {28'd0, load_slot} < 32'(PARTITION_SLOTS)) begin
      slot_valid[load_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en && {28'd0, load_slot} < 32'(PARTITION_SLOTS)) begin
      part_start[load_slot] <= load_start;
      part_len[load_slot] <= load_length;
    end
  end

  assign len_ok = ({1'b0, rel_sector} + 33'd2) <= {1'b0, sel_len};

  assign div_go = cmd.div_start;
  assign div_a = cmd.div_second ? quo : (rel_sector + sel_start);
  assign div_b = cmd.div_second ? {3'd0, heads} : spt;

  acrs_divider u_div (
    .clk(clk), .rst(rst), .start(div_go), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(quo), .remainder(rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      run_second <= 1'b0;
    end else if (div_go) begin
      run_second <= cmd.div_second;
    end
  end

  always_ff @(posedge clk) begin
    if (div_done && !run_second) sec_out <= rem + 8'd1;
    if (div_done && run_second) begin
      head_out <= rem[3:0];
      cyl_out <= quo[15:0];
    end
  end

  assign stat.div_done = div_done;
endmodule

// ===== rtl/acrs_control.sv =====
// Controller: request state, issue sequencing and result emission.
module acrs_control #(
  parameter int PARTITION_SLOTS = acrs_pkg::PartitionSlotsDef,
  parameter int DRIVE_COUNT_MAX = acrs_pkg::DriveCountMaxDef,
  parameter int ERROR_LIMIT = acrs_pkg::ErrorLimitDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          command,
  input  logic [7:0]          minor_number,
  input  logic [31:0]         start_sector,
  input  logic [7:0]          sector_count,
  input  logic                is_write,
  input  logic [7:0]          status_byte,
  input  logic [7:0]          spt0,
  input  logic [4:0]          heads0,
  input  logic [15:0]         cyl0,
  input  logic [7:0]          spt1,
  input  logic [4:0]          heads1,
  input  logic [15:0]         cyl1,
  input  logic [7:0]          control_byte,
  input  logic [15:0]         write_precomp,
  output logic [3:0]          dev,
  output logic [31:0]         rel_sector,
  output logic [7:0]          spt,
  output logic [4:0]          heads,
  output acrs_pkg::dp_cmd_t   cmd,
  input  acrs_pkg::dp_stat_t  stat,
  input  logic                len_ok,
  input  logic [7:0]          sec_in,
  input  logic [3:0]          head_in,
  input  logic [15:0]         cyl_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_kind,
  output logic [2:0]          out_port,
  output logic [7:0]          out_value,
  output logic                out_ok,
  output logic                out_last
);
  import acrs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_DIV1  = 6'b000100,
    S_DIV2  = 6'b001000,
    S_EMIT  = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state, state_next;
  logic pending_reset, pending_restore, active, cur_write;
  logic [31:0] cur_sector;
  logic [7:0] left;
  logic [2:0] errs;
  logic [1:0] kind;
  logic [3:0] step;      // result index within an emitted sequence
  logic       fin_ok;
  logic       drive;
  logic [2:0] drv_cnt;
  logic       minor_ok, cfg_ok, good;
  logic [2:0] errs_inc;
  logic [1:0] seq_kind;  // which sequence is being emitted
  logic [3:0] seq_len;
  logic [2:0] tf_idx;
  logic [7:0] op;
  logic [7:0] tf_cnt, tf_sec, tf_head;
  logic [15:0] tf_cyl;

  assign drv_cnt = (cyl1 != 16'd0 && DRIVE_COUNT_MAX > 1) ? 3'd2 : 3'd1;
  assign drive = (dev >= 4'd5);
  assign spt = drive ? spt1 : spt0;
  assign heads = drive ? heads1 : heads0;
  assign rel_sector = cur_sector;
  assign good = (status_byte & 8'hf1) == 8'h50;
  assign errs_inc = errs + 3'd1;

  function automatic logic minor_fits(input logic [7:0] m, input logic [2:0] dc);
    minor_fits = ({24'd0, m} < 32'(dc) * 32'd5) && ({24'd0, m} < 32'(PARTITION_SLOTS));
  endfunction

  assign minor_ok = minor_fits({4'd0, dev}, drv_cnt);
  assign cfg_ok = len_ok && spt != 8'd0 && heads != 5'd0 && heads <= 5'd16 && left != 8'd0;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_EMIT) || (state == S_FIN);

  always_comb begin
    cmd.div_start = 1'b0;
    cmd.div_second = (state == S_DIV2);
    if (state == S_CHECK && minor_ok && cfg_ok) cmd.div_start = 1'b1;
    if (state == S_DIV1 && stat.div_done) begin
      cmd.div_start = 1'b1;
      cmd.div_second = 1'b1;
    end
  end

  // task-file field selection
  assign seq_len = (seq_kind == KIND_SPECIFY) ? 4'd10 : 4'd8;
  assign tf_idx = (seq_kind == KIND_SPECIFY) ? 3'(step - 4'd2) : step[2:0];
  always_comb begin
    case (seq_kind)
      KIND_SPECIFY: begin
        op = OP_SPECIFY; tf_cnt = spt; tf_sec = spt;
        tf_head = {3'd0, heads - 5'd1}; tf_cyl = drive ? cyl1 : cyl0;
      end
      KIND_RESTORE: begin
        op = OP_RESTORE; tf_cnt = spt; tf_sec = 8'd0; tf_head = 8'd0; tf_cyl = 16'd0;
      end
      default: begin
        op = cur_write ? OP_WRITE : OP_READ; tf_cnt = left; tf_sec = sec_in;
        tf_head = {4'd0, head_in}; tf_cyl = cyl_in;
      end
    endcase
  end

  always_comb begin
    out_kind = (state == S_FIN);
    out_ok = (state == S_FIN) && fin_ok;
    out_port = '0;
    out_value = '0;
    out_last = (state == S_FIN) || (step == seq_len - 4'd1);
    if (state == S_EMIT) begin
      if (seq_kind == KIND_SPECIFY && step == 4'd0) begin
        out_value = CTRL_SRST;
      end else if (seq_kind == KIND_SPECIFY && step == 4'd1) begin
        out_value = control_byte & CTRL_MASK;
      end else begin
        out_port = tf_idx;
        case (tf_idx)
          3'd0: out_value = control_byte;
          3'd1: out_value = write_precomp[9:2];
          3'd2: out_value = tf_cnt;
          3'd3: out_value = tf_sec;
          3'd4: out_value = tf_cyl[7:0];
          3'd5: out_value = tf_cyl[15:8];
          3'd6: out_value = DEV_HEAD_BASE | {3'd0, drive, tf_head[3:0]};
          default: out_value = op;
        endcase
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) begin
        if (command == CMD_REQUEST && !active) begin
          state_next = minor_fits(minor_number, drv_cnt) ? S_CHECK : S_FIN;
        end else if (command == CMD_STATUS && active && kind != KIND_NONE) begin
          if (kind == KIND_XFER && good) begin
            if (left == 8'd1) state_next = S_FIN;
          end else if (!good && 32'(errs_inc) >= ERROR_LIMIT) begin
            state_next = S_FIN;
          end else begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: state_next = (minor_ok && cfg_ok) ? S_DIV1 : S_FIN;
      S_DIV1: if (stat.div_done) state_next = S_DIV2;
      S_DIV2: if (stat.div_done) state_next = S_EMIT;
      S_EMIT: if (out_ready && step == seq_len - 4'd1) state_next = S_IDLE;
      S_FIN: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pending_reset <= 1'b1;
      pending_restore <= 1'b1;
      active <= 1'b0;
      cur_write <= 1'b0;
      dev <= '0;
      cur_sector <= '0;
      left <= '0;
      errs <= '0;
      kind <= KIND_NONE;
      step <= '0;
      fin_ok <= 1'b0;
      seq_kind <= KIND_NONE;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: if (in_valid) begin
          if (command == CMD_REQUEST && !active) begin
            if (minor_fits(minor_number, drv_cnt)) begin
              active <= 1'b1;
              dev <= minor_number[3:0];
              cur_sector <= start_sector;
              left <= sector_count;
              cur_write <= is_write;
              errs <= '0;
            end else begin
              fin_ok <= 1'b0;
            end
          end else if (command == CMD_STATUS && active && kind != KIND_NONE) begin
            if (kind == KIND_XFER && good) begin
              errs <= '0;
              cur_sector <= cur_sector + 32'd1;
              left <= left - 8'd1;
              if (left == 8'd1) begin
                active <= 1'b0;
                fin_ok <= 1'b1;
              end
            end else if (!good) begin
              if (32'(errs_inc) > ERROR_LIMIT / 2) pending_reset <= 1'b1;
              if (32'(errs_inc) >= ERROR_LIMIT) begin
                active <= 1'b0;
                errs <= '0;
                fin_ok <= 1'b0;
              end else begin
                errs <= errs_inc;
              end
            end
          end
        end
        S_CHECK: begin
          step <= '0;
          if (!(minor_ok && cfg_ok)) begin
            active <= 1'b0;
            errs <= '0;
            fin_ok <= 1'b0;
          end
        end
        S_DIV2: if (stat.div_done) begin
          if (pending_reset) begin
            pending_reset <= 1'b0;
            pending_restore <= 1'b1;
            kind <= KIND_SPECIFY;
            seq_kind <= KIND_SPECIFY;
          end else if (pending_restore) begin
            pending_restore <= 1'b0;
            kind <= KIND_RESTORE;
            seq_kind <= KIND_RESTORE;
          end else begin
            kind <= KIND_XFER;
            seq_kind <= KIND_XFER;
          end
        end
        S_EMIT: if (out_ready) step <= step + 4'd1;
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/ata_chs_request_sequencer.sv =====
// Top level: configuration registers, stream ports, controller and datapath.
// One item is taken at a time. A request or status that issues commands runs
// two divisions back to back in one shared iterative divider, then emits
// eight or ten register writes, held while the receiver stalls; a rejected
// request answers from S_FIN, straight from idle if the minor number does not
// fit, else after S_CHECK. A new item is taken only once the last result of
// the previous item is transferred.
module ata_chs_request_sequencer #(
  parameter int PARTITION_SLOTS = acrs_pkg::PartitionSlotsDef,
  parameter int DRIVE_COUNT_MAX = acrs_pkg::DriveCountMaxDef,
  parameter int ERROR_LIMIT = acrs_pkg::ErrorLimitDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // slot_index[3:0] slot_start[35:4] slot_length[67:36]
  // minor_number[75:68] start_sector[107:76] sector_count[115:108]
  // is_write[116] status_byte[124:117]
  input  logic [acrs_pkg::InDataW-1:0]  s_tdata,
  input  logic [acrs_pkg::InUserW-1:0]  s_tuser,  // command
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // port_select[2:0] port_value[10:3] request_ok[11]
  output logic [acrs_pkg::OutDataW-1:0] m_tdata,
  output logic                          m_tuser,  // result_kind
  output logic                          m_tlast,  // last
  input  logic                          cfg_we,
  input  logic [acrs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [acrs_pkg::CfgDataW-1:0] cfg_data
);
  import acrs_pkg::*;

  logic [7:0] spt0, spt1, ctrl;
  logic [4:0] heads0, heads1;
  logic [15:0] cyl0, cyl1, precomp;
  logic [1:0] command;
  logic load_en;
  logic [3:0] dev;
  logic [31:0] rel_sector;
  logic [7:0] spt, sec;
  logic [4:0] heads;
  logic [3:0] head;
  logic [15:0] cyl;
  logic len_ok;
  dp_cmd_t cmd;
  dp_stat_t stat;
  logic [2:0] port;
  logic [7:0] value;
  logic ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      spt0 <= 8'd17; heads0 <= 5'd4; cyl0 <= 16'd615;
      spt1 <= 8'd17; heads1 <= 5'd4; cyl1 <= 16'd0;
      ctrl <= 8'd0; precomp <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPT0: spt0 <= cfg_data[7:0];
        REG_HEADS0: heads0 <= cfg_data[4:0];
        REG_CYL0: cyl0 <= cfg_data;
        REG_SPT1: spt1 <= cfg_data[7:0];
        REG_HEADS1: heads1 <= cfg_data[4:0];
        REG_CYL1: cyl1 <= cfg_data;
        REG_CTRL: ctrl <= cfg_data[7:0];
        REG_PRECOMP: precomp <= cfg_data;
        default: ;
      endcase
    end
  end

  assign command = s_tuser;
  assign load_en = s_tvalid && s_tready && command == CMD_LOAD;

  acrs_datapath #(.PARTITION_SLOTS(PARTITION_SLOTS)) u_dp (
    .clk(clk), .rst(rst), .load_en(load_en), .load_slot(s_tdata[3:0]),
    .load_start(s_tdata[35:4]), .load_length(s_tdata[67:36]),
    .dev(dev), .rel_sector(rel_sector), .spt(spt), .heads(heads),
    .cmd(cmd), .stat(stat), .len_ok(len_ok), .sec_out(sec),
    .head_out(head), .cyl_out(cyl)
  );

  acrs_control #(
    .PARTITION_SLOTS(PARTITION_SLOTS), .DRIVE_COUNT_MAX(DRIVE_COUNT_MAX),
    .ERROR_LIMIT(ERROR_LIMIT)
  ) u_ctl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .command(command), .minor_number(s_tdata[75:68]),
    .start_sector(s_tdata[107:76]), .sector_count(s_tdata[115:108]),
    .is_write(s_tdata[116]), .status_byte(s_tdata[124:117]),
    .spt0(spt0), .heads0(heads0), .cyl0(cyl0), .spt1(spt1), .heads1(heads1),
    .cyl1(cyl1), .control_byte(ctrl), .write_precomp(precomp),
    .dev(dev), .rel_sector(rel_sector), .spt(spt), .heads(heads),
    .cmd(cmd), .stat(stat), .len_ok(len_ok), .sec_in(sec), .head_in(head),
    .cyl_in(cyl), .out_valid(m_tvalid), .out_ready(m_tready),
    .out_kind(m_tuser), .out_port(port), .out_value(value), .out_ok(ok),
    .out_last(m_tlast)
  );

  assign m_tdata = {4'd0, ok, value, port};
endmodule

// ===== rtl/acrs_checker.sv =====
// Port-level checker for the sequencer, bound to the top level.
`include "ata_chs_request_sequencer_assert.svh"
module acrs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);
  `ACRS_ASSERT_IMP(a_no_overlap, clk, rst, m_tvalid, !s_tready)
  `ACRS_ASSERT_IMP(a_fin_last, clk, rst, m_tvalid && m_tuser, m_tlast)
  `ACRS_ASSERT_IMP(a_fin_zero, clk, rst, m_tvalid && m_tuser, m_tdata[10:0] == 11'd0)
  `ACRS_ASSERT_IMP(a_wr_not_ok, clk, rst, m_tvalid && !m_tuser, !m_tdata[11])
  `ACRS_ASSERT_NXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

bind ata_chs_request_sequencer acrs_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
  .m_tuser(m_tuser), .m_tlast(m_tlast)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the ATA CHS request sequencer: stream stimulus, predictor, checker.
module testbench;
  import acrs_pkg::*;

  typedef struct {
    logic [1:0]  command;
    logic [3:0]  slot_index;
    logic [31:0] slot_start;
    logic [31:0] slot_length;
    logic [7:0]  minor_number;
    logic [31:0] start_sector;
    logic [7:0]  sector_count;
    logic        is_write;
    logic [7:0]  status_byte;
  } disk_item_t;

  typedef struct {
    logic       kind;
    logic [2:0] port;
    logic [7:0] value;
    logic       ok;
    logic       last;
  } port_write_t;

  // how a directed row is checked
  localparam int ROW_PREDICT = 0;
  localparam int ROW_FAIL = 1;
  localparam int ROW_QUIET = 2;

  localparam int NUM_SLOTS = 10;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InDataW-1:0] s_tdata = '0;
  logic [InUserW-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic m_tuser;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  ata_chs_request_sequencer i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [7:0]  spt_r [2];
  logic [4:0]  heads_r [2];
  logic [15:0] cyl_r [2];
  logic [7:0]  ctrl_r;
  logic [15:0] precomp_r;
  logic [31:0] part_start [NUM_SLOTS];
  logic [31:0] part_len [NUM_SLOTS];
  logic        pend_reset, pend_restore, busy, cur_write;
  logic [3:0]  cur_minor;
  logic [31:0] cur_sector;
  logic [7:0]  sectors_left;
  logic [2:0]  err_count;
  logic [1:0]  issued;

  port_write_t pending_writes [$];
  port_write_t fresh [$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int quiet = 0;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  bit want_hold = 0;
  int hold_left = 0;

  function automatic void emit(logic kind, logic [2:0] port, logic [7:0] value, logic ok);
    port_write_t w;
    w.kind = kind; w.port = port; w.value = value; w.ok = ok; w.last = 1'b0;
    fresh.push_back(w);
  endfunction

  function automatic void task_file(logic drive, logic [7:0] nr, logic [7:0] sec,
                                    logic [3:0] head, logic [15:0] cyl, logic [7:0] op);
    emit(1'b0, 3'd0, ctrl_r, 1'b0);
    emit(1'b0, 3'd1, precomp_r[9:2], 1'b0);
    emit(1'b0, 3'd2, nr, 1'b0);
    emit(1'b0, 3'd3, sec, 1'b0);
    emit(1'b0, 3'd4, cyl[7:0], 1'b0);
    emit(1'b0, 3'd5, cyl[15:8], 1'b0);
    emit(1'b0, 3'd6, DEV_HEAD_BASE | {3'b0, drive, head}, 1'b0);
    emit(1'b0, 3'd7, op, 1'b0);
  endfunction

  function automatic void finish_request(logic ok);
    busy = 1'b0;
    err_count = '0;
    emit(1'b1, 3'd0, 8'd0, ok);
  endfunction

  function automatic int drives_present();
    return (cyl_r[1] != 0) ? 2 : 1;
  endfunction

  function automatic void issue_next();
    int drive;
    logic [31:0] spt, heads, absol, q;
    logic [7:0] sec;
    logic [3:0] head;
    logic [15:0] cyl;
    if (cur_minor >= drives_present() * 5 || cur_minor >= NUM_SLOTS) begin
      finish_request(1'b0);
      return;
    end
    if ({32'd0, cur_sector} + 64'd2 > {32'd0, part_len[cur_minor]}) begin
      finish_request(1'b0);
      return;
    end
    drive = cur_minor / 5;
    spt = spt_r[drive];
    heads = heads_r[drive];
    if (spt == 0 || heads == 0 || heads > 16 || sectors_left == 0) begin
      finish_request(1'b0);
      return;
    end
    absol = cur_sector + part_start[cur_minor];
    sec = 8'(absol % spt + 1);
    q = absol / spt;
    head = 4'(q % heads);
    cyl = 16'(q / heads);
    if (pend_reset) begin
      pend_reset = 1'b0;
      pend_restore = 1'b1;
      issued = KIND_SPECIFY;
      emit(1'b0, 3'd0, CTRL_SRST, 1'b0);
      emit(1'b0, 3'd0, ctrl_r & CTRL_MASK, 1'b0);
      task_file(drive[0], spt[7:0], spt[7:0], 4'(heads - 1), cyl_r[drive], OP_SPECIFY);
    end else if (pend_restore) begin
      pend_restore = 1'b0;
      issued = KIND_RESTORE;
      task_file(drive[0], spt[7:0], 8'd0, 4'd0, 16'd0, OP_RESTORE);
    end else begin
      issued = KIND_XFER;
      task_file(drive[0], sectors_left, sec, head, cyl, cur_write ? OP_WRITE : OP_READ);
    end
  endfunction

  // Works out the port writes that one accepted item causes and queues them.
  function automatic void predict_sequencer(disk_item_t it);
    logic good;
    port_write_t w;
    fresh.delete();
    good = (it.status_byte & 8'hf1) == 8'h50;
    case (it.command)
      CMD_LOAD: begin
        if (it.slot_index < NUM_SLOTS) begin
          part_start[it.slot_index] = it.slot_start;
          part_len[it.slot_index] = it.slot_length;
        end
      end
      CMD_REQUEST: begin
        if (!busy) begin
          if (it.minor_number >= drives_present() * 5 || it.minor_number >= NUM_SLOTS) begin
            emit(1'b1, 3'd0, 8'd0, 1'b0);
          end else begin
            busy = 1'b1;
            cur_minor = it.minor_number[3:0];
            cur_sector = it.start_sector;
            sectors_left = it.sector_count;
            cur_write = it.is_write;
            err_count = '0;
            issue_next();
          end
        end
      end
      CMD_STATUS: begin
        if (busy) begin
          if (issued == KIND_XFER && good) begin
            err_count = '0;
            cur_sector = cur_sector + 1;
            sectors_left = sectors_left - 1;
            if (sectors_left == 0) finish_request(1'b1);
          end else if (issued != KIND_NONE) begin
            if (!good) begin
              err_count = err_count + 1;
              if (err_count >= 7) finish_request(1'b0);
              // the failure clears the counter, so test the value just counted
              if (err_count == 0 || err_count > 3) pend_reset = 1'b1;
            end
            if (busy) issue_next();
          end
        end
      end
      default: ;
    endcase
    if (fresh.size() > 0) begin
      w = fresh.pop_back();
      w.last = 1'b1;
      fresh.push_back(w);
    end
  endfunction

  function automatic void model_reset();
    spt_r[0] = 17; heads_r[0] = 4; cyl_r[0] = 615;
    spt_r[1] = 17; heads_r[1] = 4; cyl_r[1] = 0;
    ctrl_r = 0; precomp_r = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      part_start[i] = 0;
      part_len[i] = 0;
    end
    pend_reset = 1; pend_restore = 1; busy = 0; cur_write = 0;
    cur_minor = 0; cur_sector = 0; sectors_left = 0; err_count = 0; issued = KIND_NONE;
  endfunction

  function automatic logic [InDataW-1:0] pack_item(disk_item_t it);
    logic [InDataW-1:0] d;
    d = '0;
    d[3:0] = it.slot_index;
    d[35:4] = it.slot_start;
    d[67:36] = it.slot_length;
    d[75:68] = it.minor_number;
    d[107:76] = it.start_sector;
    d[115:108] = it.sector_count;
    d[116] = it.is_write;
    d[124:117] = it.status_byte;
    return d;
  endfunction

  // Offers one item, waits for the transfer, predicts, then maybe idles.
  task automatic send_item(disk_item_t it, int mode = ROW_PREDICT, logic typed_ok = 1'b0);
    port_write_t w;
    s_tvalid <= 1'b1;
    s_tdata <= pack_item(it);
    s_tuser <= it.command;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    predict_sequencer(it);
    if (mode == ROW_PREDICT) begin
      foreach (fresh[i]) pending_writes.push_back(fresh[i]);
    end else if (mode == ROW_FAIL) begin
      w.kind = 1'b1; w.port = 3'd0; w.value = 8'd0; w.ok = typed_ok; w.last = 1'b1;
      pending_writes.push_back(w);
    end
    if ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  // Drops valid, waits until every expected write has come, then lets the block settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_writes.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [15:0] v [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CfgIdxW'(i);
      cfg_data <= v[i];
      @(posedge clk);
      case (i)
        REG_SPT0: spt_r[0] = v[i][7:0];
        REG_HEADS0: heads_r[0] = v[i][4:0];
        REG_CYL0: cyl_r[0] = v[i];
        REG_SPT1: spt_r[1] = v[i][7:0];
        REG_HEADS1: heads_r[1] = v[i][4:0];
        REG_CYL1: cyl_r[1] = v[i];
        REG_CTRL: ctrl_r = v[i][7:0];
        default: precomp_r = v[i];
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  function automatic disk_item_t blank_item(logic [1:0] cmd);
    disk_item_t it;
    it.command = cmd; it.slot_index = 0; it.slot_start = 0; it.slot_length = 0;
    it.minor_number = 0; it.start_sector = 0; it.sector_count = 1; it.is_write = 0;
    it.status_byte = 8'h50;
    return it;
  endfunction

  function automatic disk_item_t noise_item();
    disk_item_t it;
    it.command = 2'($urandom_range(3));
    it.slot_index = 4'($urandom);
    it.slot_start = $urandom;
    it.slot_length = $urandom;
    it.minor_number = 8'($urandom);
    it.start_sector = $urandom;
    it.sector_count = 8'($urandom);
    it.is_write = 1'($urandom);
    it.status_byte = 8'($urandom);
    return it;
  endfunction

  // Mostly well-formed load / request / status runs, some noise and broken runs.
  task automatic random_traffic(int target);
    disk_item_t it;
    int r, n, slot;
    while (items_sent < target) begin
      r = $urandom_range(99);
      if (r < 12) begin
        send_item(noise_item());
      end else begin
        slot = $urandom_range(drives_present() * 5 - 1);
        if (r < 20) slot = $urandom_range(15);
        it = blank_item(CMD_LOAD);
        it.slot_index = 4'(slot);
        it.slot_start = ($urandom_range(1)) ? $urandom : $urandom_range(5000);
        it.slot_length = ($urandom_range(1)) ? $urandom : $urandom_range(2, 3000);
        if ($urandom_range(9) == 0) it.slot_length = $urandom_range(1);
        send_item(it);
        it = blank_item(CMD_REQUEST);
        it.minor_number = 8'(slot);
        if (slot < NUM_SLOTS && part_len[slot] >= 2)
          it.start_sector = $urandom % (part_len[slot] - 1);
        if ($urandom_range(9) == 0) it.start_sector = $urandom;
        it.sector_count = 8'($urandom_range(1, 5));
        if ($urandom_range(19) == 0) it.sector_count = 0;
        it.is_write = 1'($urandom);
        send_item(it);
        n = 0;
        while (busy && n < 40) begin
          it = blank_item(CMD_STATUS);
          if ($urandom_range(99) < 75) it.status_byte = 8'h50 | 8'($urandom_range(7) << 1);
          else it.status_byte = 8'($urandom);
          send_item(it);
          n++;
        end
      end
    end
  endtask

  // receiver with random stalls and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (want_hold) begin
      want_hold = 0;
      hold_left = 500;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    port_write_t w;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d writes still expected", $time,
                 pending_writes.size());
        $display("FAILURE");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (pending_writes.size() == 0) begin
          $display("%0t: unexpected transfer kind=%0b port=%0d value=%02h ok=%0b last=%0b",
                   $time, m_tuser, m_tdata[2:0], m_tdata[10:3], m_tdata[11], m_tlast);
          errors++;
        end else begin
          w = pending_writes.pop_front();
          if (m_tuser !== w.kind || m_tdata[2:0] !== w.port || m_tdata[10:3] !== w.value ||
              m_tdata[11] !== w.ok || m_tlast !== w.last) begin
            $display("%0t: mismatch expected kind=%0b port=%0d value=%02h ok=%0b last=%0b",
                     $time, w.kind, w.port, w.value, w.ok, w.last);
            $display("%0t:          actual   kind=%0b port=%0d value=%02h ok=%0b last=%0b",
                     $time, m_tuser, m_tdata[2:0], m_tdata[10:3], m_tdata[11], m_tlast);
            errors++;
          end
        end
      end
    end
  end

  typedef struct {
    disk_item_t it;
    int mode;
    logic ok;
  } directed_row_t;

  directed_row_t rows [$];

  task automatic add_row(logic [1:0] cmd, logic [3:0] slot, logic [31:0] start,
                         logic [31:0] len, logic [7:0] minor, logic [31:0] ssec,
                         logic [7:0] cnt, logic wr, logic [7:0] status, int mode);
    directed_row_t r;
    r.it.command = cmd; r.it.slot_index = slot; r.it.slot_start = start;
    r.it.slot_length = len; r.it.minor_number = minor; r.it.start_sector = ssec;
    r.it.sector_count = cnt; r.it.is_write = wr; r.it.status_byte = status;
    r.mode = mode; r.ok = 1'b0;
    rows.push_back(r);
  endtask

  logic [15:0] cfg_set [8];

  initial begin
    model_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset-time geometry: only drive zero present, empty partition table
    add_row(CMD_REQUEST, 0, 0, 0, 8'd0, 0, 8'd1, 0, 8'h00, ROW_FAIL);
    add_row(CMD_REQUEST, 0, 0, 0, 8'd5, 0, 8'd1, 0, 8'h00, ROW_FAIL);
    add_row(CMD_REQUEST, 0, 0, 0, 8'hff, 32'hffffffff, 8'hff, 1, 8'h00, ROW_FAIL);
    add_row(CMD_STATUS, 0, 0, 0, 0, 0, 8'd1, 0, 8'h50, ROW_QUIET);
    add_row(2'd3, 4'hf, 32'hffffffff, 32'hffffffff, 8'hff, 32'hffffffff, 8'hff, 1,
            8'hff, ROW_QUIET);
    add_row(CMD_LOAD, 4'hf, 32'h1234, 32'h100, 0, 0, 8'd1, 0, 8'h00, ROW_QUIET);
    add_row(CMD_LOAD, 0, 32'd100, 32'd50, 0, 0, 8'd1, 0, 8'h00, ROW_QUIET);
    add_row(CMD_LOAD, 4, 32'hffffffff, 32'hffffffff, 0, 0, 8'd1, 0, 8'h00, ROW_QUIET);
    add_row(CMD_REQUEST, 0, 0, 0, 8'd0, 32'd48, 8'd2, 0, 8'h00, ROW_PREDICT);
    add_row(CMD_REQUEST, 0, 0, 0, 8'd0, 32'd0, 8'd1, 0, 8'h00, ROW_QUIET);
    add_row(CMD_STATUS, 0, 0, 0, 0, 0, 8'd1, 0, 8'h5e, ROW_PREDICT);
    add_row(CMD_STATUS, 0, 0, 0, 0, 0, 8'd1, 0, 8'h50, ROW_PREDICT);
    add_row(CMD_STATUS, 0, 0, 0, 0, 0, 8'd1, 0, 8'h52, ROW_QUIET);
    add_row(CMD_STATUS, 0, 0, 0, 0, 0, 8'd1, 0, 8'h50, ROW_PREDICT);
    // start wraps past 2^32 on slot four
    add_row(CMD_REQUEST, 0, 0, 0, 8'd4, 32'd1, 8'd2, 1, 8'h00, ROW_PREDICT);
    add_row(CMD_STATUS, 0, 0, 0, 0, 0, 8'd1, 0, 8'h51, ROW_PREDICT);
    add_row(CMD_STATUS, 0, 0, 0, 0, 0, 8'd1, 0, 8'h00, ROW_PREDICT);
    add_row(CMD_STATUS, 0, 0, 0, 0, 0, 8'd1, 0, 8'h40, ROW_PREDICT);
    add_row(CMD_STATUS, 0, 0, 0, 0, 0, 8'd1, 0, 8'hf1, ROW_PREDICT);
    add_row(CMD_STATUS, 0, 0, 0, 0, 0, 8'd1, 0, 8'hd0, ROW_PREDICT);
    add_row(CMD_STATUS, 0, 0, 0, 0, 0, 8'd1, 0, 8'h10, ROW_PREDICT);
    add_row(CMD_STATUS, 0, 0, 0, 0, 0, 8'd1, 0, 8'h01, ROW_FAIL);
    add_row(CMD_REQUEST, 0, 0, 0, 8'd0, 32'd0, 8'd0, 0, 8'h00, ROW_FAIL);
    foreach (rows[i]) send_item(rows[i].it, rows[i].mode, rows[i].ok);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          cfg_set = '{16'd17, 16'd4, 16'd615, 16'd63, 16'd16, 16'd1024, 16'h08, 16'd300};
          sender_idle_pct = 0; stall_pct = 0;
        end
        1: begin
          cfg_set = '{16'd255, 16'd16, 16'hffff, 16'd255, 16'd16, 16'hffff, 16'hff, 16'hffff};
          sender_idle_pct = 87; stall_pct = 0;
        end
        2: begin
          cfg_set = '{16'd1, 16'd1, 16'd0, 16'd1, 16'd1, 16'd1, 16'h00, 16'd0};
          sender_idle_pct = 0; stall_pct = 87;
        end
        3: begin
          // degenerate geometry: rejections on either drive
          cfg_set = '{16'd0, 16'd31, 16'd100, 16'd20, 16'd0, 16'd5, 16'h5a, 16'd4};
          sender_idle_pct = 26; stall_pct = 26;
        end
        4: begin
          cfg_set = '{16'd9, 16'd17, 16'd2, 16'd63, 16'd15, 16'd0, 16'ha5, 16'd1023};
          sender_idle_pct = 26; stall_pct = 26;
        end
        default: begin
          cfg_set = '{16'd63, 16'd16, 16'd4096, 16'd32, 16'd8, 16'd900, 16'h0c, 16'd512};
          sender_idle_pct = 0; stall_pct = 0;
          want_hold = 1;
        end
      endcase
      configure(cfg_set);
      random_traffic(rows.size() + (ph + 1) * 43);
      drain();
    end

    $display("Covered %0d items and %0d result transfers over six geometry settings,",
             items_sent, results_seen);
    $display("with reset, restore, read/write, retry and rejection paths under back-pressure.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
